FILE: hdl/assert_macros.svh
// Assertion macros of the deframer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define LPWD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

`define LPWD_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`else

`define LPWD_ASSERT(lbl, clk, rstn, prop, msg)

`define LPWD_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

FILE: hdl/lpwd_pkg.sv
// Shared types and codes of the length-prefixed word deframer
`timescale 1ns / 1ps
`default_nettype none

package lpwd_pkg;

    localparam int MAX_WORD_DEFAULT = 4095;
    localparam int LEN_W            = 12;
    localparam logic [LEN_W-1:0] MAX_WORD_LENGTH_RESET = 12'd4095;

    // Phase codes
    localparam logic [1:0] PH_WAIT = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;

    // Result kinds
    localparam logic [1:0] K_DATA = 2'd0;
    localparam logic [1:0] K_END  = 2'd1;
    localparam logic [1:0] K_RESV = 2'd2;
    localparam logic [1:0] K_LONG = 2'd3;

    // Word classes
    localparam logic [1:0] CL_STATUS = 2'd0;
    localparam logic [1:0] CL_ATTR   = 2'd1;
    localparam logic [1:0] CL_OTHER  = 2'd2;

    localparam logic [7:0] CHAR_BANG  = 8'h21;
    localparam logic [7:0] CHAR_EQUAL = 8'h3D;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic [1:0] word_class;
        logic       word_first;
        logic       word_last;
        logic       is_separator;
        logic       in_value;
    } lpwd_result_t;

endpackage

`default_nettype wire

FILE: hdl/lpwd_core.sv
// Prefix decoder, payload counter and byte tagger of the deframer
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lpwd_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_accept,
    input  wire logic [7:0]                       in_byte,
    input  wire logic [lpwd_pkg::LEN_W-1:0]       limit,
    output logic                                  res_valid,
    output lpwd_pkg::lpwd_result_t                res
);
    import lpwd_pkg::*;

    logic [1:0]       phase_reg, phase_next;
    logic [2:0]       prefix_left_reg, prefix_left_next;
    logic [LEN_W-1:0] accum_reg, accum_next;
    logic             big_reg, big_next;
    logic [LEN_W-1:0] payload_left_reg, payload_left_next;
    logic [1:0]       class_reg, class_next;
    logic             first_pending_reg, first_pending_next;
    logic             sep_seen_reg, sep_seen_next;

    logic [LEN_W-1:0] accum_shift;
    logic             big_shift;
    logic             do_len;
    logic [LEN_W-1:0] len_val;
    logic             len_big;
    logic             last;

    // Shift in one more length byte; keep only a sticky flag for high bits
    assign accum_shift = {accum_reg[LEN_W-9:0], in_byte};
    assign big_shift   = big_reg | (accum_reg[LEN_W-1:LEN_W-8] != 8'd0);

    always_comb
    begin
        phase_next         = phase_reg;
        prefix_left_next   = prefix_left_reg;
        accum_next         = accum_reg;
        big_next           = big_reg;
        payload_left_next  = payload_left_reg;
        class_next         = class_reg;
        first_pending_next = first_pending_reg;
        sep_seen_next      = sep_seen_reg;
        res_valid          = 1'b0;
        res                = '{out_byte: 8'd0, kind: K_DATA, word_class: CL_OTHER,
                               word_first: 1'b0, word_last: 1'b0,
                               is_separator: 1'b0, in_value: 1'b0};
        do_len             = 1'b0;
        len_val            = '0;
        len_big            = 1'b0;
        last               = 1'b0;

        unique case (phase_reg)
            PH_LEN:
            begin
                accum_next       = accum_shift;
                big_next         = big_shift;
                prefix_left_next = prefix_left_reg - 3'd1;
                if (prefix_left_reg == 3'd1)
                begin
                    do_len  = 1'b1;
                    len_val = accum_shift;
                    len_big = big_shift;
                end
            end
            PH_DATA:
            begin
                res.out_byte = in_byte;
                if (first_pending_reg)
                begin
                    if (in_byte == CHAR_BANG)
                        class_next = CL_STATUS;
                    else if (in_byte == CHAR_EQUAL)
                        class_next = CL_ATTR;
                    else
                        class_next = CL_OTHER;
                    first_pending_next = 1'b0;
                end
                else if (class_reg == CL_ATTR)
                begin
                    if (sep_seen_reg)
                        res.in_value = 1'b1;
                    else if (in_byte == CHAR_EQUAL)
                    begin
                        res.is_separator = 1'b1;
                        sep_seen_next    = 1'b1;
                    end
                end
                last              = (payload_left_reg <= LEN_W'(1));
                payload_left_next = last ? '0 : payload_left_reg - LEN_W'(1);
                if (last)
                    phase_next = PH_WAIT;
                res_valid       = 1'b1;
                res.word_class  = class_next;
                res.word_first  = first_pending_reg;
                res.word_last   = last;
            end
            default:
            begin
                // Waiting for a length prefix (unused phase code behaves the same)
                if (in_byte == 8'hF0)
                begin
                    accum_next       = '0;
                    big_next         = 1'b0;
                    prefix_left_next = 3'd4;
                    phase_next       = PH_LEN;
                end
                else if (in_byte[7:4] == 4'hF)
                begin
                    phase_next = PH_WAIT;
                    res_valid  = 1'b1;
                    res.kind   = K_RESV;
                end
                else if (in_byte[7:5] == 3'b111)
                begin
                    accum_next       = {4'd0, 3'd0, in_byte[4:0]};
                    big_next         = 1'b0;
                    prefix_left_next = 3'd3;
                    phase_next       = PH_LEN;
                end
                else if (in_byte[7:6] == 2'b11)
                begin
                    accum_next       = {4'd0, 2'd0, in_byte[5:0]};
                    big_next         = 1'b0;
                    prefix_left_next = 3'd2;
                    phase_next       = PH_LEN;
                end
                else if (in_byte[7] == 1'b1)
                begin
                    accum_next       = {4'd0, 1'b0, in_byte[6:0]};
                    big_next         = 1'b0;
                    prefix_left_next = 3'd1;
                    phase_next       = PH_LEN;
                end
                else
                begin
                    accum_next = {4'd0, in_byte};
                    big_next   = 1'b0;
                    do_len     = 1'b1;
                    len_val    = {4'd0, in_byte};
                end
            end
        endcase

        // Length complete: check it and open the payload, or flag an empty/long word
        if (do_len)
        begin
            phase_next       = PH_WAIT;
            prefix_left_next = 3'd0;
            if (len_big || (len_val > limit))
            begin
                res_valid = 1'b1;
                res.kind  = K_LONG;
            end
            else if (len_val == '0)
            begin
                res_valid = 1'b1;
                res.kind  = K_END;
            end
            else
            begin
                payload_left_next  = len_val;
                phase_next         = PH_DATA;
                first_pending_next = 1'b1;
                sep_seen_next      = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_WAIT;
            prefix_left_reg   <= 3'd0;
            accum_reg         <= '0;
            big_reg           <= 1'b0;
            payload_left_reg  <= '0;
            class_reg         <= CL_STATUS;
            first_pending_reg <= 1'b1;
            sep_seen_reg      <= 1'b0;
        end
        else if (in_accept)
        begin
            phase_reg         <= phase_next;
            prefix_left_reg   <= prefix_left_next;
            accum_reg         <= accum_next;
            big_reg           <= big_next;
            payload_left_reg  <= payload_left_next;
            class_reg         <= class_next;
            first_pending_reg <= first_pending_next;
            sep_seen_reg      <= sep_seen_next;
        end
    end

    `LPWD_ASSERT(a_no_unused_phase, clk, rst_n, phase_reg != 2'd3, "unused phase code reached")
    `LPWD_ASSERT_IMPL(a_data_has_bytes, clk, rst_n, phase_reg == PH_DATA, payload_left_reg != '0, "payload phase with no bytes left")
    `LPWD_ASSERT_IMPL(a_len_count, clk, rst_n, phase_reg == PH_LEN, (prefix_left_reg != 3'd0) && (prefix_left_reg <= 3'd4), "length byte count out of range")
    `LPWD_ASSERT_IMPL(a_sep_attr_only, clk, rst_n, res_valid && res.is_separator, (res.word_class == CL_ATTR) && !res.word_first && !sep_seen_reg, "separator outside attribute word")

endmodule

`default_nettype wire

FILE: hdl/lpwd_out_reg.sv
// Output register of the deframer result stream
`timescale 1ns / 1ps
`default_nettype none

module lpwd_out_reg (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      load,
    input  wire lpwd_pkg::lpwd_result_t    res,
    output logic                           ready,
    output logic                           valid,
    input  wire logic                      take,
    output lpwd_pkg::lpwd_result_t         data
);
    import lpwd_pkg::*;

    logic         valid_reg;
    lpwd_result_t data_reg;

    // Accept a new transaction whenever the register is empty or the held result leaves this cycle
    assign ready = !valid_reg || take;
    assign valid = valid_reg;
    assign data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (take)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= res;
    end

endmodule

`default_nettype wire

FILE: hdl/length_prefixed_word_deframer.sv
// Top level of the length-prefixed word deframer
`timescale 1ns / 1ps
`default_nettype none

// A result appears on m_tvalid in the cycle after the byte transaction that causes it.
// Throughput: one byte per cycle, set by the state update of the prefix decoder
// and payload counter; a byte is taken only while the output register is empty or its result
// leaves in the same cycle, so a held result stalls every byte, prefix bytes included.
// Reset (rst_n low, asynchronous): wait for a length prefix, no result held, max_word_length 4095.

module length_prefixed_word_deframer #(
    parameter int MAX_WORD = lpwd_pkg::MAX_WORD_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Received byte stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,   // [7:0] in_byte
    // Tagged payload and marker stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [7:0]                         m_tdata,   // [7:0] out_byte
    output logic [6:0]                         m_tuser,   // [1:0] kind, [3:2] word_class,
                                                          // [4] word_first, [5] is_separator,
                                                          // [6] in_value
    output logic                               m_tlast,   // word_last
    // Configuration: max_word_length
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [lpwd_pkg::LEN_W-1:0]    cfg_data
);
    import lpwd_pkg::*;

    localparam logic [16:0] MaxWordW = 17'(MAX_WORD);

    logic [LEN_W-1:0] max_len_reg;
    logic [LEN_W-1:0] limit;
    logic             in_accept;
    logic             res_valid;
    lpwd_result_t     res;
    lpwd_result_t     out_data;

    // Configuration writes are always taken; the block is idle by contract
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_len_reg <= MAX_WORD_LENGTH_RESET;
        else if (cfg_valid && cfg_ready)
            max_len_reg <= cfg_data;
    end

    // Limit in force: the smaller of the register and the build-time ceiling
    assign limit = ({5'd0, max_len_reg} < MaxWordW) ? max_len_reg : MaxWordW[LEN_W-1:0];

    assign in_accept = s_tvalid && s_tready;

    lpwd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .limit     (limit),
        .res_valid (res_valid),
        .res       (res)
    );

    // Load the result register only when the accepted byte yields a result
    lpwd_out_reg u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (in_accept && res_valid),
        .res   (res),
        .ready (s_tready),
        .valid (m_tvalid),
        .take  (m_tready),
        .data  (out_data)
    );

    assign m_tdata = out_data.out_byte;
    assign m_tuser = {out_data.in_value, out_data.is_separator, out_data.word_first,
                      out_data.word_class, out_data.kind};
    assign m_tlast = out_data.word_last;

endmodule

`default_nettype wire
